### hw/rtl/rsr_pkg.sv
// Shared types, constants and the per-entry op sequence for the symmetry reduction block.
package rsr_pkg;

	// Table size and derived address layout of the working RAM
	localparam int MAX_SYM   = 24;
	localparam int SYM_AW    = (MAX_SYM > 1) ? $clog2(MAX_SYM) : 1;
	localparam int REGION_AW = (SYM_AW > 5) ? SYM_AW : 5;
	localparam int RAM_AW    = REGION_AW + 2;
	localparam int RAM_DEPTH = 1 << RAM_AW;
	localparam int ENT_W     = REGION_AW + 1;

	localparam logic [4:0]  SYM_COUNT_RST = 5'd24;
	localparam logic [31:0] DIST_LIMIT    = 32'h4CBE_BC20; // 1e8
	localparam logic [31:0] FP_ONE        = 32'h3F80_0000;
	localparam logic [31:0] FP_QNAN       = 32'h7FC0_0000;

	// RAM regions: three table components and a scratch area
	localparam logic [1:0] REG_X   = 2'd0;
	localparam logic [1:0] REG_Y   = 2'd1;
	localparam logic [1:0] REG_Z   = 2'd2;
	localparam logic [1:0] REG_SCR = 2'd3;

	typedef struct packed {
		logic        op;
		logic [4:0]  sym_index;
		logic [31:0] sym_x;
		logic [31:0] sym_y;
		logic [31:0] sym_z;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
	} item_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic        found;
	} result_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_REDUCE = 1'b1;

	typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fop_t;

	// Operand slots; SX/SY/SZ address the current table entry
	typedef enum logic [4:0] {
		SL_R1, SL_R2, SL_R3, SL_ONE, SL_P1, SL_P2, SL_P3, SL_DOT, SL_DEN,
		SL_A, SL_B, SL_X, SL_C1, SL_C2, SL_C3, SL_D1, SL_D2, SL_D3, SL_DIST,
		SL_SX, SL_SY, SL_SZ
	} slot_t;

	typedef struct packed {
		fop_t  fop;
		slot_t src_a;
		slot_t src_b;
		slot_t dst;
	} ustep_t;

	typedef struct packed {
		logic        start;
		fop_t        fop;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} fpu_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_INIT, ST_READ, ST_EXEC, ST_WAIT, ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SETUP, F_ADD, F_DPRE, F_DIV, F_NORM, F_RND, F_DONE
	} fpu_state_t;

	localparam int         UP_LEN  = 29;
	localparam logic [4:0] UP_LAST = 5'(UP_LEN - 1);

	// One entry's composition, one rounded op per step
	function automatic ustep_t ucode(input logic [4:0] step);
		ustep_t u;
		case (step)
			5'd0:  u = '{FOP_MUL, SL_R1,  SL_SX,  SL_P1};
			5'd1:  u = '{FOP_MUL, SL_R2,  SL_SY,  SL_P2};
			5'd2:  u = '{FOP_MUL, SL_R3,  SL_SZ,  SL_P3};
			5'd3:  u = '{FOP_ADD, SL_P1,  SL_P2,  SL_DOT};
			5'd4:  u = '{FOP_ADD, SL_DOT, SL_P3,  SL_DOT};
			5'd5:  u = '{FOP_SUB, SL_ONE, SL_DOT, SL_DEN};
			5'd6:  u = '{FOP_MUL, SL_R3,  SL_SY,  SL_A};
			5'd7:  u = '{FOP_MUL, SL_R2,  SL_SZ,  SL_B};
			5'd8:  u = '{FOP_SUB, SL_A,   SL_B,   SL_X};
			5'd9:  u = '{FOP_ADD, SL_R1,  SL_SX,  SL_C1};
			5'd10: u = '{FOP_SUB, SL_C1,  SL_X,   SL_C1};
			5'd11: u = '{FOP_DIV, SL_C1,  SL_DEN, SL_C1};
			5'd12: u = '{FOP_MUL, SL_R1,  SL_SZ,  SL_A};
			5'd13: u = '{FOP_MUL, SL_R3,  SL_SX,  SL_B};
			5'd14: u = '{FOP_SUB, SL_A,   SL_B,   SL_X};
			5'd15: u = '{FOP_ADD, SL_R2,  SL_SY,  SL_C2};
			5'd16: u = '{FOP_SUB, SL_C2,  SL_X,   SL_C2};
			5'd17: u = '{FOP_DIV, SL_C2,  SL_DEN, SL_C2};
			5'd18: u = '{FOP_MUL, SL_R2,  SL_SX,  SL_A};
			5'd19: u = '{FOP_MUL, SL_R1,  SL_SY,  SL_B};
			5'd20: u = '{FOP_SUB, SL_A,   SL_B,   SL_X};
			5'd21: u = '{FOP_ADD, SL_R3,  SL_SZ,  SL_C3};
			5'd22: u = '{FOP_SUB, SL_C3,  SL_X,   SL_C3};
			5'd23: u = '{FOP_DIV, SL_C3,  SL_DEN, SL_C3};
			5'd24: u = '{FOP_MUL, SL_C1,  SL_C1,  SL_D1};
			5'd25: u = '{FOP_MUL, SL_C2,  SL_C2,  SL_D2};
			5'd26: u = '{FOP_MUL, SL_C3,  SL_C3,  SL_D3};
			5'd27: u = '{FOP_ADD, SL_D1,  SL_D2,  SL_DIST};
			5'd28: u = '{FOP_ADD, SL_DIST, SL_D3, SL_DIST};
			default: u = '{FOP_ADD, SL_DIST, SL_D3, SL_DIST};
		endcase
		return u;
	endfunction

endpackage

### hw/rtl/rsr_ram.sv
// Generic RAM: one write port, two registered read ports.
module rsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### hw/rtl/rsr_fpu.sv
// Shared multi-cycle single precision unit: add, subtract, multiply, divide, round to nearest even.
module rsr_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  rsr_pkg::fpu_req_t req,
	output rsr_pkg::fpu_rsp_t rsp
);

	rsr_pkg::fpu_state_t state_q, state_d;
	rsr_pkg::fop_t       fop_q;
	logic [31:0]         a_q, b_q, res_q;
	logic [47:0]         raw_q;
	logic signed [11:0]  exp_q, ea_q, eb_q;
	logic                sign_q, zsign_q, st_q, sub_q;
	logic [26:0]         big_q, small_q, quo_q;
	logic [23:0]         ma_q, mb_q;
	logic [24:0]         rem_q;
	logic [4:0]          cnt_q;

	// Operand unpack
	logic               sa, sb, sx;
	logic [7:0]         efa, efb;
	logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0]        ma, mb;
	logic signed [11:0] ea, eb;

	always_comb begin
		sa     = a_q[31];
		sb     = b_q[31] ^ (fop_q == rsr_pkg::FOP_SUB);
		sx     = a_q[31] ^ b_q[31];
		efa    = a_q[30:23];
		efb    = b_q[30:23];
		a_nan  = (&efa) && (|a_q[22:0]);
		b_nan  = (&efb) && (|b_q[22:0]);
		a_inf  = (&efa) && !(|a_q[22:0]);
		b_inf  = (&efb) && !(|b_q[22:0]);
		a_zero = !(|a_q[30:0]);
		b_zero = !(|b_q[30:0]);
		ma     = {|efa, a_q[22:0]};
		mb     = {|efb, b_q[22:0]};
		ea     = (efa == 8'd0) ? 12'sd1 : $signed({4'b0, efa});
		eb     = (efb == 8'd0) ? 12'sd1 : $signed({4'b0, efb});
	end

	// Special operands: NaN, infinity, zero short cuts
	logic        spec_hit;
	logic [31:0] spec_val;

	always_comb begin
		spec_hit = 1'b0;
		spec_val = rsr_pkg::FP_QNAN;
		case (fop_q)
			rsr_pkg::FOP_ADD, rsr_pkg::FOP_SUB: begin
				if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
					spec_hit = 1'b1;
				end else if (a_inf) begin
					spec_hit = 1'b1;
					spec_val = {sa, 8'hFF, 23'd0};
				end else if (b_inf) begin
					spec_hit = 1'b1;
					spec_val = {sb, 8'hFF, 23'd0};
				end
			end
			rsr_pkg::FOP_MUL: begin
				if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
					spec_hit = 1'b1;
				end else if (a_inf || b_inf) begin
					spec_hit = 1'b1;
					spec_val = {sx, 8'hFF, 23'd0};
				end else if (a_zero || b_zero) begin
					spec_hit = 1'b1;
					spec_val = {sx, 31'd0};
				end
			end
			default: begin
				if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
					spec_hit = 1'b1;
				end else if (a_inf || b_zero) begin
					spec_hit = 1'b1;
					spec_val = {sx, 8'hFF, 23'd0};
				end else if (b_inf || a_zero) begin
					spec_hit = 1'b1;
					spec_val = {sx, 31'd0};
				end
			end
		endcase
	end

	// Add alignment: larger magnitude first, smaller shifted with sticky
	logic               swap;
	logic [23:0]        m_big, m_small;
	logic signed [11:0] e_big, e_small, e_diff;
	logic [26:0]        small_ext, aligned;

	always_comb begin
		swap      = (b_q[30:0] > a_q[30:0]);
		m_big     = swap ? mb : ma;
		m_small   = swap ? ma : mb;
		e_big     = swap ? eb : ea;
		e_small   = swap ? ea : eb;
		e_diff    = e_big - e_small;
		small_ext = {m_small, 3'b000};
		if (e_diff > 12'sd26) begin
			aligned = {26'd0, |m_small};
		end else begin
			aligned    = small_ext >> e_diff[4:0];
			aligned[0] = aligned[0] | (|(small_ext & ~({27{1'b1}} << e_diff[4:0])));
		end
	end

	logic [27:0] add_sum;
	assign add_sum = sub_q ? ({1'b0, big_q} - {1'b0, small_q})
	                       : ({1'b0, big_q} + {1'b0, small_q});

	// One restoring divide step
	logic        div_ge;
	logic [24:0] div_diff;
	logic [26:0] quo_next;

	always_comb begin
		div_ge   = (rem_q >= {1'b0, mb_q});
		div_diff = div_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
		quo_next = {quo_q[25:0], div_ge};
	end

	// Rounding with gradual underflow
	logic [26:0]        sig, sig_d;
	logic signed [11:0] sh, e_d, e_r;
	logic [23:0]        mant, m_fin;
	logic [24:0]        m25;
	logic               inc;
	logic [31:0]        rnd_val;

	always_comb begin
		sig = {raw_q[47:22], (|raw_q[21:0]) | st_q};
		sh  = 12'sd1 - exp_q;
		if (exp_q < 12'sd1) begin
			if (sh > 12'sd26) begin
				sig_d = {26'd0, |sig};
			end else begin
				sig_d    = sig >> sh[4:0];
				sig_d[0] = sig_d[0] | (|(sig & ~({27{1'b1}} << sh[4:0])));
			end
			e_d = 12'sd1;
		end else begin
			sig_d = sig;
			e_d   = exp_q;
		end
		mant = sig_d[26:3];
		inc  = sig_d[2] && ((|sig_d[1:0]) || mant[0]);
		m25  = {1'b0, mant} + {24'd0, inc};
		if (m25[24]) begin
			m_fin = m25[24:1];
			e_r   = e_d + 12'sd1;
		end else begin
			m_fin = m25[23:0];
			e_r   = e_d;
		end
		if (e_r > 12'sd254) begin
			rnd_val = {sign_q, 8'hFF, 23'd0};
		end else begin
			rnd_val = {sign_q, (m_fin[23] ? e_r[7:0] : 8'h00), m_fin[22:0]};
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsr_pkg::F_IDLE: begin
				if (req.start) begin
					state_d = rsr_pkg::F_SETUP;
				end
			end
			rsr_pkg::F_SETUP: begin
				if (spec_hit) begin
					state_d = rsr_pkg::F_DONE;
				end else if (fop_q == rsr_pkg::FOP_MUL) begin
					state_d = rsr_pkg::F_NORM;
				end else if (fop_q == rsr_pkg::FOP_DIV) begin
					state_d = rsr_pkg::F_DPRE;
				end else begin
					state_d = rsr_pkg::F_ADD;
				end
			end
			rsr_pkg::F_ADD:  state_d = rsr_pkg::F_NORM;
			rsr_pkg::F_DPRE: begin
				if (ma_q[23] && mb_q[23]) begin
					state_d = rsr_pkg::F_DIV;
				end
			end
			rsr_pkg::F_DIV: begin
				if (cnt_q == 5'd26) begin
					state_d = rsr_pkg::F_NORM;
				end
			end
			rsr_pkg::F_NORM: begin
				if (raw_q == 48'd0) begin
					state_d = rsr_pkg::F_DONE;
				end else if (raw_q[47]) begin
					state_d = rsr_pkg::F_RND;
				end
			end
			rsr_pkg::F_RND:  state_d = rsr_pkg::F_DONE;
			rsr_pkg::F_DONE: state_d = rsr_pkg::F_IDLE;
			default:         state_d = rsr_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsr_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	always_comb begin
		rsp.done = (state_q == rsr_pkg::F_DONE);
		rsp.res  = res_q;
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rsr_pkg::F_IDLE: begin
				if (req.start) begin
					fop_q <= req.fop;
					a_q   <= req.a;
					b_q   <= req.b;
				end
			end
			rsr_pkg::F_SETUP: begin
				res_q <= spec_val;
				st_q  <= 1'b0;
				case (fop_q)
					rsr_pkg::FOP_MUL: begin
						raw_q   <= ma * mb;
						exp_q   <= ea + eb - 12'sd126;
						sign_q  <= sx;
						zsign_q <= sx;
					end
					rsr_pkg::FOP_DIV: begin
						ma_q   <= ma;
						mb_q   <= mb;
						ea_q   <= ea;
						eb_q   <= eb;
						sign_q <= sx;
						zsign_q <= sx;
					end
					default: begin
						big_q   <= {m_big, 3'b000};
						small_q <= aligned;
						sub_q   <= (sa != sb);
						exp_q   <= e_big + 12'sd1;
						sign_q  <= swap ? sb : sa;
						zsign_q <= sa & sb;
					end
				endcase
			end
			rsr_pkg::F_ADD: begin
				raw_q <= {add_sum, 20'd0};
			end
			rsr_pkg::F_DPRE: begin
				if (!ma_q[23]) begin
					ma_q <= {ma_q[22:0], 1'b0};
					ea_q <= ea_q - 12'sd1;
				end
				if (!mb_q[23]) begin
					mb_q <= {mb_q[22:0], 1'b0};
					eb_q <= eb_q - 12'sd1;
				end
				rem_q <= {1'b0, ma_q};
				quo_q <= 27'd0;
				cnt_q <= 5'd0;
			end
			rsr_pkg::F_DIV: begin
				quo_q <= quo_next;
				rem_q <= {div_diff[23:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd26) begin
					raw_q <= {quo_next, 21'd0};
					st_q  <= |div_diff;
					exp_q <= ea_q - eb_q + 12'sd127;
				end
			end
			rsr_pkg::F_NORM: begin
				if (raw_q == 48'd0) begin
					res_q <= {zsign_q, 31'd0};
				end else if (raw_q[47:40] == 8'd0) begin
					raw_q <= {raw_q[39:0], 8'd0};
					exp_q <= exp_q - 12'sd8;
				end else if (!raw_q[47]) begin
					raw_q <= {raw_q[46:0], 1'b0};
					exp_q <= exp_q - 12'sd1;
				end
			end
			rsr_pkg::F_RND: begin
				res_q <= rnd_val;
			end
			default: ;
		endcase
	end

	// A new op only lands on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == rsr_pkg::F_IDLE))
		else $error("fpu started while busy");

	// Partial remainder stays below twice the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsr_pkg::F_DIV) |-> (rem_q < {mb_q, 1'b0}))
		else $error("divide remainder out of range");

endmodule

### hw/rtl/rodrigues_symmetry_reduce_top.sv
// Top level: symmetry table, op sequencer and best-composite tracking.
//
// A load beat with an index below 24 writes one table entry, its x, y and z
// components in turn. A reduce beat first writes the vector and the constant
// one into scratch, then runs for each of the first min(sym_count, 24) entries
// a fixed sequence of 29 single precision ops through one shared float unit;
// each op is read from the two-port operand RAM only after that unit has
// finished the op before it. busy is high for the whole item; the result is on
// result for exactly one cycle with done high, and must be taken then.
module rodrigues_symmetry_reduce_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rsr_pkg::item_t   item,
	output logic             done,
	output rsr_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_wdata
);

	rsr_pkg::top_state_t            state_q, state_d;
	rsr_pkg::item_t                 item_q;
	logic [4:0]                     sym_count_q;
	logic [1:0]                     cnt_q;
	logic [rsr_pkg::ENT_W-1:0]      entry_q, n_q, n_lim;
	logic [4:0]                     step_q;
	logic [31:0]                    best_q, cand_x_q, cand_y_q, cand_z_q;
	logic [31:0]                    m_x_q, m_y_q, m_z_q;
	logic                           found_q;

	rsr_pkg::ustep_t                u;
	rsr_pkg::fpu_req_t              fpu_req;
	rsr_pkg::fpu_rsp_t              fpu_rsp;
	logic                           ram_we;
	logic [rsr_pkg::RAM_AW-1:0]     waddr, raddr_a, raddr_b;
	logic [31:0]                    wdata, rdata_a, rdata_b;
	logic                           load_ok, last_entry, dist_nan, dist_lt;

	// Operand slot to RAM address
	function automatic logic [rsr_pkg::RAM_AW-1:0] slot_addr(
		input rsr_pkg::slot_t slot, input logic [rsr_pkg::ENT_W-1:0] ent);
		logic [rsr_pkg::RAM_AW-1:0] a;
		case (slot)
			rsr_pkg::SL_SX: a = {rsr_pkg::REG_X, ent[rsr_pkg::REGION_AW-1:0]};
			rsr_pkg::SL_SY: a = {rsr_pkg::REG_Y, ent[rsr_pkg::REGION_AW-1:0]};
			rsr_pkg::SL_SZ: a = {rsr_pkg::REG_Z, ent[rsr_pkg::REGION_AW-1:0]};
			default:        a = {rsr_pkg::REG_SCR, rsr_pkg::REGION_AW'(slot)};
		endcase
		return a;
	endfunction

	assign u          = rsr_pkg::ucode(step_q);
	assign load_ok    = (rsr_pkg::ENT_W'(item.sym_index) < rsr_pkg::ENT_W'(rsr_pkg::MAX_SYM));
	assign n_lim      = (rsr_pkg::ENT_W'(sym_count_q) > rsr_pkg::ENT_W'(rsr_pkg::MAX_SYM))
	                  ? rsr_pkg::ENT_W'(rsr_pkg::MAX_SYM) : rsr_pkg::ENT_W'(sym_count_q);
	assign last_entry = ((entry_q + 1'b1) == n_q);
	assign dist_nan   = (&fpu_rsp.res[30:23]) && (|fpu_rsp.res[22:0]);
	assign dist_lt    = !dist_nan && !fpu_rsp.res[31] && (fpu_rsp.res[30:0] < best_q[30:0]);

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= rsr_pkg::SYM_COUNT_RST;
		end else if (cfg_we) begin
			sym_count_q <= cfg_wdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsr_pkg::ST_IDLE: begin
				if (start) begin
					if (item.op == rsr_pkg::OP_REDUCE) begin
						state_d = rsr_pkg::ST_INIT;
					end else if (load_ok) begin
						state_d = rsr_pkg::ST_LOAD;
					end
				end
			end
			rsr_pkg::ST_LOAD: begin
				if (cnt_q == 2'd2) begin
					state_d = rsr_pkg::ST_IDLE;
				end
			end
			rsr_pkg::ST_INIT: begin
				if (cnt_q == 2'd3) begin
					state_d = (n_q == '0) ? rsr_pkg::ST_OUT : rsr_pkg::ST_READ;
				end
			end
			rsr_pkg::ST_READ: state_d = rsr_pkg::ST_EXEC;
			rsr_pkg::ST_EXEC: state_d = rsr_pkg::ST_WAIT;
			rsr_pkg::ST_WAIT: begin
				if (fpu_rsp.done) begin
					if (step_q == rsr_pkg::UP_LAST && last_entry) begin
						state_d = rsr_pkg::ST_OUT;
					end else begin
						state_d = rsr_pkg::ST_READ;
					end
				end
			end
			rsr_pkg::ST_OUT: state_d = rsr_pkg::ST_IDLE;
			default:         state_d = rsr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsr_pkg::ST_IDLE;
			cnt_q   <= 2'd0;
			step_q  <= 5'd0;
			entry_q <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rsr_pkg::ST_IDLE: begin
					cnt_q   <= 2'd0;
					step_q  <= 5'd0;
					entry_q <= '0;
					n_q     <= n_lim;
				end
				rsr_pkg::ST_LOAD, rsr_pkg::ST_INIT: cnt_q <= cnt_q + 2'd1;
				rsr_pkg::ST_WAIT: begin
					if (fpu_rsp.done) begin
						if (step_q == rsr_pkg::UP_LAST) begin
							step_q  <= 5'd0;
							entry_q <= entry_q + 1'b1;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Outputs and RAM/unit controls
	always_comb begin
		busy    = (state_q != rsr_pkg::ST_IDLE);
		done    = (state_q == rsr_pkg::ST_OUT);
		result  = '{out_x: m_x_q, out_y: m_y_q, out_z: m_z_q, found: found_q};
		raddr_a = slot_addr(u.src_a, entry_q);
		raddr_b = slot_addr(u.src_b, entry_q);
		fpu_req = '{start: (state_q == rsr_pkg::ST_EXEC), fop: u.fop, a: rdata_a, b: rdata_b};
		ram_we  = 1'b0;
		waddr   = slot_addr(u.dst, entry_q);
		wdata   = fpu_rsp.res;
		case (state_q)
			rsr_pkg::ST_LOAD: begin
				ram_we = 1'b1;
				case (cnt_q)
					2'd0: begin
						waddr = {rsr_pkg::REG_X, rsr_pkg::REGION_AW'(item_q.sym_index)};
						wdata = item_q.sym_x;
					end
					2'd1: begin
						waddr = {rsr_pkg::REG_Y, rsr_pkg::REGION_AW'(item_q.sym_index)};
						wdata = item_q.sym_y;
					end
					default: begin
						waddr = {rsr_pkg::REG_Z, rsr_pkg::REGION_AW'(item_q.sym_index)};
						wdata = item_q.sym_z;
					end
				endcase
			end
			rsr_pkg::ST_INIT: begin
				ram_we = 1'b1;
				case (cnt_q)
					2'd0: begin
						waddr = slot_addr(rsr_pkg::SL_R1, entry_q);
						wdata = item_q.vec_x;
					end
					2'd1: begin
						waddr = slot_addr(rsr_pkg::SL_R2, entry_q);
						wdata = item_q.vec_y;
					end
					2'd2: begin
						waddr = slot_addr(rsr_pkg::SL_R3, entry_q);
						wdata = item_q.vec_z;
					end
					default: begin
						waddr = slot_addr(rsr_pkg::SL_ONE, entry_q);
						wdata = rsr_pkg::FP_ONE;
					end
				endcase
			end
			rsr_pkg::ST_WAIT: ram_we = fpu_rsp.done;
			default: ;
		endcase
	end

	// Input beat capture and best-composite tracking
	always_ff @(posedge clk) begin
		if (state_q == rsr_pkg::ST_IDLE && start) begin
			item_q  <= item;
			best_q  <= rsr_pkg::DIST_LIMIT;
			m_x_q   <= 32'd0;
			m_y_q   <= 32'd0;
			m_z_q   <= 32'd0;
			found_q <= 1'b0;
		end
		if (state_q == rsr_pkg::ST_WAIT && fpu_rsp.done) begin
			if (u.dst == rsr_pkg::SL_C1) cand_x_q <= fpu_rsp.res;
			if (u.dst == rsr_pkg::SL_C2) cand_y_q <= fpu_rsp.res;
			if (u.dst == rsr_pkg::SL_C3) cand_z_q <= fpu_rsp.res;
			if (step_q == rsr_pkg::UP_LAST && dist_lt) begin
				best_q  <= fpu_rsp.res;
				m_x_q   <= cand_x_q;
				m_y_q   <= cand_y_q;
				m_z_q   <= cand_z_q;
				found_q <= 1'b1;
			end
		end
	end

	rsr_ram #(
		.WIDTH(32),
		.DEPTH(rsr_pkg::RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	rsr_fpu u_fpu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (fpu_req),
		.rsp   (fpu_rsp)
	);

	// After the result beat the block is free again
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result beat");

	// If no composite qualifies, the result vector is all zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |->
		(result.out_x == 32'd0 && result.out_y == 32'd0 && result.out_z == 32'd0))
		else $error("nonzero result without match");

endmodule
